FILE: hdl/latency_bandwidth_link_queue_top_assert.svh
// Assertion macros shared by the link queue modules.
`ifndef LATENCY_BANDWIDTH_LINK_QUEUE_TOP_ASSERT_SVH
`define LATENCY_BANDWIDTH_LINK_QUEUE_TOP_ASSERT_SVH

// Immediate implication checked every cycle outside reset.
`define LBLQ_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define LBLQ_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: hdl/lblq_pkg.sv
package lblq_pkg;

   localparam int PendDepth = 16;
   localparam int WaitDepth = 8;
   localparam int PendIdxW  = (PendDepth > 1) ? $clog2(PendDepth) : 1;
   localparam int PendCntW  = $clog2(PendDepth + 1);
   localparam int WaitIdxW  = (WaitDepth > 1) ? $clog2(WaitDepth) : 1;
   localparam int WaitCntW  = $clog2(WaitDepth + 1);
   localparam int TimeW     = 48;
   localparam int SizeW     = 13;
   localparam int TagW      = 8;
   localparam int QDepth    = 2;

   typedef enum logic [1:0] {
      ACT_REQ   = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_GRANT = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_ACCEPT  = 3'd0,
      KIND_DENY    = 3'd1,
      KIND_FORWARD = 3'd2,
      KIND_LATE    = 3'd3,
      KIND_DROP    = 3'd4
   } kind_type;

   localparam logic [1:0] CSR_LATENCY = 2'd0;
   localparam logic [1:0] CSR_WIDTH   = 2'd1;
   localparam logic [1:0] CSR_LIMIT   = 2'd2;

   // One classified command handed from the front end to the back end.
   typedef struct packed {
      action_type       action;
      logic [TagW-1:0]  tag;
      logic [SizeW-1:0] size;
      logic             ds_ready;
   } cmd_type;

endpackage

FILE: hdl/lblq_front.sv
module lblq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_action,
   input  logic [7:0]       req_req_tag,
   input  logic [12:0]      req_req_size,
   input  logic             req_downstream_ready,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output lblq_pkg::cmd_type cmd_data
);
   import lblq_pkg::*;

   cmd_type              q_ff [QDepth];
   logic [0:0]           rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0]           cnt_ff, cnt_in;
   cmd_type              new_cmd;
   logic                 push, pop;

   assign req_ready = (cnt_ff != 2'(QDepth));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = q_ff[rd_ff];

   always_comb begin
      new_cmd.action   = action_type'(req_action);
      new_cmd.tag      = req_req_tag;
      new_cmd.size     = req_req_size;
      new_cmd.ds_ready = req_downstream_ready;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= new_cmd;
      end
   end

   `include "latency_bandwidth_link_queue_top_assert.svh"
   `LBLQ_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff <= 2'(QDepth), "queue overcount")
   `LBLQ_ASSERT_NEXT(a_push_only, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 2'd1, "push lost")
   `LBLQ_ASSERT_NEXT(a_pop_only, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 2'd1, "pop lost")

endmodule

FILE: hdl/lblq_back.sv
module lblq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  lblq_pkg::cmd_type cmd_data,
   input  logic [9:0]        cfg_latency,
   input  logic [8:0]        cfg_width,
   input  logic [15:0]       cfg_limit,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_kind,
   output logic [7:0]        rsp_out_tag,
   output logic [12:0]       rsp_out_size,
   output logic              rsp_stalled_now,
   output logic              rsp_last
);
   import lblq_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_HEAD  = 6'b000010,
      ST_GRANT = 6'b000100,
      ST_FWD   = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Pending storage: tag, size and ready time.
   logic [TagW-1:0]  ptag_ff  [PendDepth];
   logic [SizeW-1:0] psize_ff [PendDepth];
   logic [TimeW-1:0] pready_ff[PendDepth];
   logic [PendIdxW-1:0] phead_ff, phead_in;
   logic [PendCntW-1:0] pcnt_ff, pcnt_in;
   logic [TagW-1:0]  wtag_ff  [WaitDepth];
   logic [SizeW-1:0] wsize_ff [WaitDepth];
   logic [WaitIdxW-1:0] whead_ff, whead_in;
   logic [WaitCntW-1:0] wcnt_ff, wcnt_in;
   logic [16:0]      pbytes_ff, pbytes_in;
   logic [TimeW-1:0] now_ff, now_in, nsend_ff, nsend_in;
   logic             stall_ff, stall_in;
   logic [SizeW-1:0] ssize_ff, ssize_in;

   // Head snapshot and divider.
   logic [TagW-1:0]  htag_ff, htag_in;
   logic [SizeW-1:0] hsize_ff, hsize_in;
   logic             hrdy_ff, hrdy_in;
   logic [SizeW:0]   dq_ff, dq_in;
   logic [SizeW+9:0] drem_ff, drem_in;
   logic [3:0]       dcnt_ff, dcnt_in;
   logic [1:0]       ctxt_ff, ctxt_in;

   // Output register.
   logic             ov_ff, ov_in;
   logic [2:0]       ok_ff, ok_in;
   logic [TagW-1:0]  ot_ff, ot_in;
   logic [SizeW-1:0] os_ff, os_in;
   logic             ost_ff, ost_in, ol_ff, ol_in;

   logic [PendIdxW-1:0] ptail;
   logic [WaitIdxW-1:0] wtail;
   logic                pfull, wfull, fit_req, fit_wait, can_emit;
   logic                pwr, wwr;
   logic [TagW-1:0]     pwr_tag;
   logic [SizeW-1:0]    pwr_size;
   logic [TimeW-1:0]    when, hready, dsum;
   logic [SizeW+9:0]    dshift;

   function automatic logic fits(input logic [16:0] pb, input logic [15:0] lim,
                                 input logic full, input logic [SizeW-1:0] sz);
      logic [17:0] s;
      s = 18'(pb) + 18'(sz);
      return !full && ((pb == 17'd0) || (lim == 16'd0) || (s <= 18'(lim)));
   endfunction

   always_comb begin
      // Both store depths are powers of two, so the indexes wrap on their own.
      ptail    = phead_ff + PendIdxW'(pcnt_ff);
      wtail    = whead_ff + WaitIdxW'(wcnt_ff);
      pfull    = (pcnt_ff == PendCntW'(PendDepth));
      wfull    = (wcnt_ff == WaitCntW'(WaitDepth));
      fit_req  = fits(pbytes_ff, cfg_limit, pfull, cmd_data.size);
      fit_wait = fits(pbytes_ff, cfg_limit, pfull, wsize_ff[whead_ff]);
      hready   = pready_ff[phead_ff];
      when     = (hready > nsend_ff) ? hready : nsend_ff;
      can_emit = !ov_ff || rsp_ready;
      dshift   = {1'b0, cfg_width, 13'd0} >> dcnt_ff;
      dsum     = now_ff + TimeW'(dq_ff);
   end

   always_comb begin
      state_in = state_ff;
      phead_in = phead_ff; pcnt_in = pcnt_ff;
      whead_in = whead_ff; wcnt_in = wcnt_ff;
      pbytes_in = pbytes_ff; now_in = now_ff; nsend_in = nsend_ff;
      stall_in = stall_ff; ssize_in = ssize_ff;
      htag_in = htag_ff; hsize_in = hsize_ff; hrdy_in = hrdy_ff;
      dq_in = dq_ff; drem_in = drem_ff; dcnt_in = dcnt_ff; ctxt_in = ctxt_ff;
      ov_in = ov_ff && !rsp_ready;
      ok_in = ok_ff; ot_in = ot_ff; os_in = os_ff; ost_in = ost_ff; ol_in = ol_ff;
      cmd_ready = 1'b0;
      pwr = 1'b0; pwr_tag = cmd_data.tag; pwr_size = cmd_data.size;
      wwr = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && can_emit) begin
               cmd_ready = 1'b1;
               case (cmd_data.action)
                  ACT_REQ: begin
                     ov_in = 1'b1; ot_in = cmd_data.tag; os_in = cmd_data.size;
                     ost_in = 1'b0; ol_in = 1'b1;
                     if (wcnt_ff == '0 && fit_req) begin
                        pwr = 1'b1; ok_in = KIND_ACCEPT;
                     end else if (!wfull) begin
                        wwr = 1'b1; ok_in = KIND_DENY;
                     end else begin
                        ok_in = KIND_DROP;
                     end
                  end
                  ACT_TICK: begin
                     now_in = now_ff + TimeW'(1);
                     hrdy_in = cmd_data.ds_ready;
                     if (!stall_ff && pcnt_ff != '0) begin
                        state_in = ST_HEAD;
                     end
                  end
                  ACT_GRANT: begin
                     if (stall_ff) begin
                        stall_in = 1'b0; ctxt_in = 2'd1;
                        dq_in = '0; dcnt_in = '0;
                        drem_in = (SizeW+10)'(ssize_ff) + (SizeW+10)'(cfg_width)
                                  - (SizeW+10)'(cfg_width != 9'd0);
                        state_in = ST_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_HEAD: begin
            if (now_ff >= when) begin
               htag_in = ptag_ff[phead_ff]; hsize_in = psize_ff[phead_ff];
               phead_in = phead_ff + PendIdxW'(1);
               pcnt_in = pcnt_ff - PendCntW'(1);
               pbytes_in = pbytes_ff - 17'(psize_ff[phead_ff]);
               state_in = ST_GRANT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_GRANT: begin
            if (wcnt_ff != '0 && fit_wait) begin
               if (can_emit) begin
                  pwr = 1'b1; pwr_tag = wtag_ff[whead_ff]; pwr_size = wsize_ff[whead_ff];
                  whead_in = whead_ff + WaitIdxW'(1);
                  wcnt_in = wcnt_ff - WaitCntW'(1);
                  ov_in = 1'b1; ok_in = KIND_LATE; ot_in = wtag_ff[whead_ff];
                  os_in = wsize_ff[whead_ff]; ost_in = 1'b0; ol_in = 1'b0;
               end
            end else begin
               if (hrdy_ff) begin
                  ctxt_in = 2'd2; dq_in = '0; dcnt_in = '0;
                  drem_in = (SizeW+10)'(hsize_ff) + (SizeW+10)'(cfg_width)
                            - (SizeW+10)'(cfg_width != 9'd0);
                  state_in = ST_DIV;
               end else begin
                  stall_in = 1'b1; ssize_in = hsize_ff;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle, MSB first; a zero width gives a quotient of one.
            if (cfg_width == 9'd0) begin
               dq_in = (SizeW+1)'(1);
               dcnt_in = 4'(SizeW + 1);
            end else begin
               if (drem_ff >= dshift) begin
                  drem_in = drem_ff - dshift;
                  dq_in = dq_ff | ((SizeW+1)'(1) << (4'(SizeW) - dcnt_ff));
               end
               dcnt_in = dcnt_ff + 4'd1;
            end
            if (dcnt_ff == 4'(SizeW) || cfg_width == 9'd0) begin
               state_in = ST_EMIT;
               if (cfg_width != 9'd0) begin
                  dq_in = (dq_in == '0) ? (SizeW+1)'(1) : dq_in;
               end
            end
         end
         ST_EMIT: begin
            if (ctxt_ff == 2'd1) begin
               nsend_in = dsum;
               ctxt_in = 2'd0;
               state_in = ST_IDLE;
            end else if (can_emit) begin
               if (hrdy_ff) nsend_in = dsum;
               ov_in = 1'b1; ok_in = KIND_FORWARD; ot_in = htag_ff; os_in = hsize_ff;
               ost_in = !hrdy_ff; ol_in = 1'b1;
               ctxt_in = 2'd0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (pwr) begin
         pcnt_in = pcnt_in + PendCntW'(1);
         pbytes_in = pbytes_in + 17'(pwr_size);
      end
      if (wwr) wcnt_in = wcnt_ff + WaitCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phead_ff <= '0; pcnt_ff <= '0; whead_ff <= '0; wcnt_ff <= '0;
         pbytes_ff <= '0; now_ff <= '0; nsend_ff <= '0;
         stall_ff <= 1'b0; ssize_ff <= '0; ov_ff <= 1'b0; ctxt_ff <= '0;
      end else begin
         state_ff <= state_in;
         phead_ff <= phead_in; pcnt_ff <= pcnt_in;
         whead_ff <= whead_in; wcnt_ff <= wcnt_in;
         pbytes_ff <= pbytes_in; now_ff <= now_in; nsend_ff <= nsend_in;
         stall_ff <= stall_in; ssize_ff <= ssize_in; ov_ff <= ov_in; ctxt_ff <= ctxt_in;
      end
      htag_ff <= htag_in; hsize_ff <= hsize_in; hrdy_ff <= hrdy_in;
      dq_ff <= dq_in; drem_ff <= drem_in; dcnt_ff <= dcnt_in;
      ok_ff <= ok_in; ot_ff <= ot_in; os_ff <= os_in; ost_ff <= ost_in; ol_ff <= ol_in;
      if (pwr) begin
         ptag_ff[ptail] <= pwr_tag;
         psize_ff[ptail] <= pwr_size;
         pready_ff[ptail] <= now_ff + TimeW'(cfg_latency);
      end
      if (wwr) begin
         wtag_ff[wtail] <= cmd_data.tag;
         wsize_ff[wtail] <= cmd_data.size;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_kind        = ok_ff;
   assign rsp_out_tag     = ot_ff;
   assign rsp_out_size    = os_ff;
   assign rsp_stalled_now = ost_ff;
   assign rsp_last        = ol_ff;

   `include "latency_bandwidth_link_queue_top_assert.svh"
   `LBLQ_ASSERT_IMPL(a_pcnt, clock, reset, 1'b1, pcnt_ff <= PendCntW'(PendDepth), "pending overflow")
   `LBLQ_ASSERT_IMPL(a_wcnt, clock, reset, 1'b1, wcnt_ff <= WaitCntW'(WaitDepth), "waiting overflow")
   `LBLQ_ASSERT_NEXT(a_hold, clock, reset, ov_ff && !rsp_ready, ov_ff && $stable(ot_ff), "result lost")
   `LBLQ_ASSERT_IMPL(a_stall_nofwd, clock, reset, stall_ff, state_ff != ST_HEAD, "forward while stalled")

endmodule

FILE: hdl/latency_bandwidth_link_queue_top.sv
// Link queue with fixed latency and bandwidth limit.
// Input channel (req_): each transfer carries one action: a request arrival
// (tag and byte size), one clock tick of link time, a downstream grant or no action.
// Result channel (rsp_): accept, deny, drop, late grant and forward records;
// rsp_last marks the final record caused by one input transfer.
// Configuration channel (csr_): index 0 latency, 1 bytes per tick, 2 pending
// byte limit; write only while the block is idle.
// A two-entry command queue separates the front end from the back end.
// A request yields its record through the command queue and the result register.
// A tick that forwards takes the back end through the head, grant, divider and
// emit states, staying in the grant state while late grants go out; the divider
// computes the transfer duration and is skipped for a refused forward.
// A downstream grant while stalled runs the divider and the emit state.
// The back end handles one command at a time.
// Reset empties both request stores, clears the link time, stall state and
// configuration registers, and drops any undelivered result.
// When the receiver stalls, the result register holds its transfer and the
// back end waits; the command queue then fills and req_ready falls.
module latency_bandwidth_link_queue_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_req_tag,
   input  logic [12:0] req_req_size,
   input  logic        req_downstream_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_out_tag,
   output logic [12:0] rsp_out_size,
   output logic        rsp_stalled_now,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import lblq_pkg::*;

   logic [9:0]  lat_ff;
   logic [8:0]  wid_ff;
   logic [15:0] lim_ff;
   logic        cmd_valid, cmd_ready;
   cmd_type     cmd_data;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= '0;
         wid_ff <= '0;
         lim_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LATENCY: lat_ff <= csr_data[9:0];
            CSR_WIDTH:   wid_ff <= csr_data[8:0];
            CSR_LIMIT:   lim_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lblq_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_req_tag,
      .req_req_size, .req_downstream_ready, .cmd_valid, .cmd_ready, .cmd_data
   );

   lblq_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .cfg_latency(lat_ff), .cfg_width(wid_ff), .cfg_limit(lim_ff),
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_out_tag, .rsp_out_size,
      .rsp_stalled_now, .rsp_last
   );

endmodule
